// ----- rtl/core/gsmin_pkg.sv -----
`timescale 1ns / 1ps
package gsmin_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_SHIFT = 16;
  localparam int PT_W        = 24;          // point width
  localparam int DIFF_W      = PT_W + 1;    // b - a
  localparam int VAL_W       = 48;          // cubic value
  localparam int SQ_W        = 33;          // x*x >>> FRAC_BITS, signed container
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = DIFF_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int CNT_W       = 8;

  localparam logic signed [MUL_A_W-1:0] RATIO_HI = 33'sd40503;
  localparam logic signed [MUL_A_W-1:0] RATIO_LO = 33'sd25033;
  localparam logic signed [VAL_W-1:0]   VAL_OFFSET = 48'sd8 <<< FRAC_BITS;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd40;

  // Microcode
  localparam int STEP_W = 5;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIFF,
    OP_MULK,
    OP_PROBE,
    OP_SQR,
    OP_CUBE,
    OP_VALUE,
    OP_SWAP,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    SIDE_LO,
    SIDE_HI,
    SIDE_FLAG
  } side_t;

  typedef enum logic {
    JMP_NONE,
    JMP_MORE
  } jmp_t;

  typedef struct packed {
    op_t              op;
    side_t            side;
    jmp_t             jmp;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // Datapath control bundle
  typedef struct packed {
    logic  load;
    op_t   op;
    side_t side;
  } ctl_t;

  localparam logic [STEP_W-1:0] STEP_LOOP = 5'd11;

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{op: OP_DONE, side: SIDE_LO, jmp: JMP_NONE, target: '0};
    unique case (step)
      5'd0:  w.op = OP_DIFF;
      5'd1:  begin w.op = OP_MULK;  w.side = SIDE_LO; end
      5'd2:  begin w.op = OP_PROBE; w.side = SIDE_LO; end
      5'd3:  w.op = OP_SQR;
      5'd4:  w.op = OP_CUBE;
      5'd5:  begin w.op = OP_VALUE; w.side = SIDE_LO; end
      5'd6:  begin w.op = OP_MULK;  w.side = SIDE_HI; end
      5'd7:  begin w.op = OP_PROBE; w.side = SIDE_HI; end
      5'd8:  w.op = OP_SQR;
      5'd9:  w.op = OP_CUBE;
      5'd10: begin w.op = OP_VALUE; w.side = SIDE_HI; end
      5'd11: w.op = OP_SWAP;
      5'd12: begin w.op = OP_MULK;  w.side = SIDE_FLAG; end
      5'd13: begin w.op = OP_PROBE; w.side = SIDE_FLAG; end
      5'd14: w.op = OP_SQR;
      5'd15: w.op = OP_CUBE;
      5'd16: begin
        w.op     = OP_VALUE;
        w.side   = SIDE_FLAG;
        w.jmp    = JMP_MORE;
        w.target = STEP_LOOP;
      end
      default: w.op = OP_DONE;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/golden_section_minimizer.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                      Beat contents
// input     start & !busy                  interval_start, interval_end (Q8.16)
// result    done (one-cycle strobe)        best_point, best_value, iterations_done,
//                                          final_width
// config    APB write, psel&penable&pwrite  reg 0 @ 0x0: iteration_limit[7:0]
//
// Iterations: a search runs N iterations, N = iteration_limit
// (0 counts as 1); the reset limit is 40. Each iteration is six
// microcode steps around the single shared 33x25 multiplier (probe, x^2, x^3).
// Reset: synchronous, active high; iteration_limit returns to 40, sequencer idles.
// Stalls: none on the result side; done pulses one cycle as busy drops, and a
// new start is taken in that same cycle.
module golden_section_minimizer import gsmin_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PT_W-1:0]  interval_start,
  input  logic signed [PT_W-1:0]  interval_end,
  // result channel
  output logic                    done,
  output logic signed [PT_W-1:0]  best_point,
  output logic signed [VAL_W-1:0] best_value,
  output logic [CNT_W-1:0]        iterations_done,
  output logic [PT_W-1:0]         final_width,
  // APB config
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [CNT_W-1:0]  iteration_limit;
  logic [CNT_W-1:0]  iteration_count;
  logic [STEP_W-1:0] step;
  logic              running;

  ucw_t              uw;
  ctl_t              ctl;
  logic              accept;
  logic              more;
  logic [CNT_W-1:0]  eff_limit;

  logic signed [PT_W-1:0]  lo_point;
  logic signed [VAL_W-1:0] lo_value;
  logic [PT_W-1:0]         span;

  // ---- config: one register, word 0; anything at word 1 is ignored
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, iteration_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      iteration_limit <= pwdata[CNT_W-1:0];
    end
  end

  // ---- microcode sequencer
  assign accept    = start && !busy;
  assign busy      = running;
  assign uw        = ucode_rom(step);
  assign eff_limit = (iteration_limit == '0) ? CNT_W'(1) : iteration_limit;
  assign more      = iteration_count < eff_limit;

  assign ctl.load = accept;
  assign ctl.op   = running ? uw.op : OP_IDLE;
  assign ctl.side = uw.side;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
      iteration_count <= '0;
    end else begin
      // result strobe is registered from the done step and rises in the cycle after it
      done <= running && (uw.op == OP_DONE);
      if (accept) begin
        running <= 1'b1;
        step    <= '0;
        iteration_count <= '0;
      end else if (running) begin
        if (uw.op == OP_SWAP) iteration_count <= iteration_count + CNT_W'(1);
        // loop back while iterations remain, else fall through to the done step
        if (uw.op == OP_DONE) begin
          running <= 1'b0;
        end else if (uw.jmp == JMP_MORE && more) begin
          step <= uw.target;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  // result beat registered at the done step
  always_ff @(posedge clk) begin
    if (running && uw.op == OP_DONE) begin
      best_point      <= lo_point;
      best_value      <= lo_value;
      iterations_done <= iteration_count;
      final_width     <= span;
    end
  end

  gsmin_datapath u_dp (
    .clk            (clk),
    .ctl            (ctl),
    .interval_start (interval_start),
    .interval_end   (interval_end),
    .lo_point       (lo_point),
    .lo_value       (lo_value),
    .span           (span)
  );

endmodule

// ----- rtl/core/gsmin_datapath.sv -----
`timescale 1ns / 1ps
module gsmin_datapath import gsmin_pkg::*; (
  input  logic                    clk,
  input  ctl_t                    ctl,
  input  logic signed [PT_W-1:0]  interval_start,
  input  logic signed [PT_W-1:0]  interval_end,
  output logic signed [PT_W-1:0]  lo_point,
  output logic signed [VAL_W-1:0] lo_value,
  output logic [PT_W-1:0]         span
);

  logic signed [PT_W-1:0]    left_end, right_end, low_probe, high_probe, x;
  logic signed [VAL_W-1:0]   low_value, high_value;
  logic signed [DIFF_W-1:0]  d;
  logic signed [SQ_W-1:0]    sq;
  logic signed [PROD_W-1:0]  prod;
  logic                      move_left;

  logic                      side_hi;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PT_W-1:0]    new_probe;
  logic signed [SQ_W-1:0]    sq_now;
  logic signed [PROD_W-1:0]  cube_full;
  logic signed [VAL_W-1:0]   f_val;
  logic                      lt;
  logic signed [DIFF_W-1:0]  span_diff;

  assign side_hi = (ctl.side == SIDE_HI) || ((ctl.side == SIDE_FLAG) && move_left);

  // sq is nonnegative and below 2^31, so the slice is exact
  assign sq_now = prod[FRAC_BITS+SQ_W-1:FRAC_BITS];

  always_comb begin
    mul_a = MUL_A_W'(x);
    mul_b = MUL_B_W'(x);
    unique case (ctl.op)
      OP_MULK: begin
        mul_a = side_hi ? RATIO_HI : RATIO_LO;
        mul_b = d;
      end
      OP_CUBE: mul_a = sq_now;
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // probe stays between the ends, so the 24-bit wrap is exact
  assign new_probe = left_end + prod[RATIO_SHIFT+PT_W-1:RATIO_SHIFT];

  // |f| stays below 2^39 for 24-bit x: no saturation can occur
  assign cube_full = prod >>> FRAC_BITS;
  assign f_val = cube_full[VAL_W-1:0] + VAL_W'(sq)
               - {{(VAL_W-PT_W-3){x[PT_W-1]}}, x, 3'b000} - VAL_OFFSET;

  assign lt = low_value < high_value;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      left_end  <= interval_start;
      right_end <= interval_end;
    end else begin
      unique case (ctl.op)
        OP_DIFF: d <= DIFF_W'(right_end) - DIFF_W'(left_end);
        OP_MULK, OP_SQR: prod <= mul_p;
        OP_PROBE: begin
          x <= new_probe;
          if (side_hi) high_probe <= new_probe;
          else         low_probe  <= new_probe;
        end
        OP_CUBE: begin
          sq   <= sq_now;
          prod <= mul_p;
        end
        OP_VALUE: begin
          if (side_hi) high_value <= f_val;
          else         low_value  <= f_val;
        end
        OP_SWAP: begin
          move_left <= lt;
          if (lt) begin
            left_end  <= low_probe;
            low_probe <= high_probe;
            low_value <= high_value;
            d         <= DIFF_W'(right_end) - DIFF_W'(low_probe);
          end else begin
            right_end  <= high_probe;
            high_probe <= low_probe;
            high_value <= low_value;
            d          <= DIFF_W'(high_probe) - DIFF_W'(left_end);
          end
        end
        default: ;
      endcase
    end
  end

  assign span_diff = DIFF_W'(right_end) - DIFF_W'(left_end);
  assign span      = span_diff[DIFF_W-1] ? PT_W'(-span_diff) : span_diff[PT_W-1:0];
  assign lo_point  = low_probe;
  assign lo_value  = low_value;

endmodule

// ----- rtl/core/gsmin_checker.sv -----
`timescale 1ns / 1ps
module gsmin_checker import gsmin_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [CNT_W-1:0] iterations_done
);

  // result beat only as the search ends
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  // a taken command starts a search
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");

  // every search ends in a result beat
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("search ended without result");

  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> iterations_done != '0) else $error("zero iterations reported");

endmodule

bind golden_section_minimizer gsmin_checker u_gsmin_checker (.*);
